>>> sv/igmp_snp_pkg.sv
// Shared constants and types for the IGMP snooping forward table.
// No dependencies; imported by the top level.
package igmp_snp_pkg;

    localparam int PORT_COUNT  = 8;
    localparam int GROUP_COUNT = 16;
    localparam int PORT_W      = 3;
    localparam int GROUP_W     = 4;
    localparam int STAMP_DEPTH = GROUP_COUNT * PORT_COUNT;
    localparam int STAMP_AW    = GROUP_W + PORT_W;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_PURGE = 2'd2;

    localparam logic [1:0] VERDICT_FWD   = 2'd0;
    localparam logic [1:0] VERDICT_BCAST = 2'd1;
    localparam logic [1:0] VERDICT_BAD   = 2'd2;

    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_IGMP = 8'd2;
    localparam logic [7:0]  T_QUERY    = 8'h11;
    localparam logic [7:0]  T_REPORT2  = 8'h16;
    localparam logic [7:0]  T_REPORT3  = 8'h22;
    localparam logic [7:0]  T_LEAVE    = 8'h17;

    localparam logic [15:0] TIMEOUT_RESET = 16'd260;

endpackage

>>> sv/igmp_snooping_forward_table_top.sv
// IGMP snooping forward table, top level.
// Depends on igmp_snp_pkg for constants and codes.
//
// One beat enters on the s_ side and one result beat leaves on the m_ side for it.
// A frame beat walks the 16 group entries one per cycle through a single address
// comparator, then applies its update in ST_APPLY before its result in ST_OUT. A
// tick goes from the accept straight to ST_OUT. A purge walks all 128 member
// stamps one per cycle through one subtract-and-compare unit reading the stamp
// memory, then judges the last read in ST_PWAIT before ST_OUT. The input is not
// ready while a beat is in progress; the result waits in the output register
// until taken.
// member_timeout may be written at any time the block is idle.
module igmp_snooping_forward_table_top
    import igmp_snp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: ingress_port[2:0], frame_length[18:3], eth_type[34:19],
    // ip_header_words[38:35], ip_protocol[46:39], igmp_type[54:47],
    // igmp_group[86:55], ip_dest[118:87], zero fill to 120 bits
    input  logic [119:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: forward_mask[7:0], table_full[8], zero fill to 16 bits
    output logic [15:0]  m_tdata,
    // tuser: verdict[1:0]
    output logic [1:0]   m_tuser
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_PURGE  = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;
    localparam logic [2:0] ST_PWAIT  = 3'd5;

    logic [2:0]  state_reg;
    logic [15:0] timeout_reg;
    logic [31:0] seconds_reg;
    logic [7:0]  qset_reg;

    logic [GROUP_COUNT-1:0] gvalid_reg;
    logic [GROUP_COUNT-1:0] qknown_reg;
    logic [31:0]            gaddr_reg [GROUP_COUNT];
    logic [PORT_W-1:0]      qport_reg [GROUP_COUNT];
    logic [7:0]             mmask_reg [GROUP_COUNT];
    logic [31:0]            stamp_mem [STAMP_DEPTH];

    // Latched beat.
    logic [2:0]  port_reg;
    logic [15:0] len_reg;
    logic [15:0] etype_reg;
    logic [3:0]  ihl_reg;
    logic [7:0]  proto_reg;
    logic [7:0]  itype_reg;
    logic [31:0] grp_reg;
    logic [31:0] dest_reg;

    // Scan results.
    logic [GROUP_W:0]   idx_reg;      // walk counter, one extra bit for the end
    logic               hit_reg;
    logic [GROUP_W-1:0] hit_idx_reg;
    logic               free_reg;
    logic [GROUP_W-1:0] free_idx_reg;

    // Purge walk.
    logic [STAMP_AW:0]   pidx_reg;
    logic [STAMP_AW-1:0] prd_addr_reg;
    logic                prd_vld_reg;
    logic [31:0]         prd_data_reg;

    logic [1:0]  verdict_reg;
    logic [7:0]  mask_reg;
    logic        full_reg;

    logic               stamp_we;
    logic [STAMP_AW-1:0] stamp_waddr;

    // Header checks settle the path before the scan.
    logic [17:0] iphl;
    logic        len_short, len_ip_bad, len_igmp_bad, is_ip, is_igmp;
    logic        is_query, is_report, is_leave;
    logic [31:0] key;

    assign iphl         = {12'd0, ihl_reg, 2'b00};
    assign len_short    = len_reg < 16'd14;
    assign is_ip        = etype_reg == ETH_IPV4;
    assign len_ip_bad   = (len_reg < 16'd34) || ({2'b00, len_reg} < 18'd14 + iphl);
    assign is_igmp      = proto_reg == PROTO_IGMP;
    assign len_igmp_bad = {2'b00, len_reg} < 18'd22 + iphl;
    assign is_query     = itype_reg == T_QUERY;
    assign is_report    = (itype_reg == T_REPORT2) || (itype_reg == T_REPORT3);
    assign is_leave     = itype_reg == T_LEAVE;
    assign key          = is_igmp ? grp_reg : dest_reg;

    logic [GROUP_W-1:0] scan_i;
    logic               scan_match;
    assign scan_i     = idx_reg[GROUP_W-1:0];
    assign scan_match = gvalid_reg[scan_i] && (gaddr_reg[scan_i] == key);

    logic [7:0] pbit;
    assign pbit = 8'd1 << port_reg;

    function automatic logic [7:0] pbit_q(input logic [PORT_W-1:0] p);
        pbit_q = 8'd1 << p;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {7'd0, full_reg, mask_reg};
    assign m_tuser  = verdict_reg;

    // Stamp memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (stamp_we) begin
            stamp_mem[stamp_waddr] <= seconds_reg;
        end
        prd_data_reg <= stamp_mem[pidx_reg[STAMP_AW-1:0]];
    end

    always_comb begin
        stamp_we    = 1'b0;
        stamp_waddr = {hit_idx_reg, port_reg};
        if (state_reg == ST_APPLY && !verdict_reg[1] && !verdict_reg[0] &&
            is_igmp && is_report && grp_reg != 32'd0) begin
            if (hit_reg) begin
                stamp_we = 1'b1;
            end else if (free_reg) begin
                stamp_we    = 1'b1;
                stamp_waddr = {free_idx_reg, port_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            timeout_reg <= TIMEOUT_RESET;
            seconds_reg <= 32'd0;
            qset_reg    <= 8'd0;
            gvalid_reg  <= '0;
            qknown_reg  <= '0;
            prd_vld_reg <= 1'b0;
            for (int g = 0; g < GROUP_COUNT; g++) begin
                mmask_reg[g] <= 8'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            prd_vld_reg  <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        port_reg    <= s_tdata[2:0];
                        len_reg     <= s_tdata[18:3];
                        etype_reg   <= s_tdata[34:19];
                        ihl_reg     <= s_tdata[38:35];
                        proto_reg   <= s_tdata[46:39];
                        itype_reg   <= s_tdata[54:47];
                        grp_reg     <= s_tdata[86:55];
                        dest_reg    <= s_tdata[118:87];
                        verdict_reg <= VERDICT_FWD;
                        mask_reg    <= 8'd0;
                        full_reg    <= 1'b0;
                        idx_reg     <= '0;
                        hit_reg     <= 1'b0;
                        free_reg    <= 1'b0;
                        pidx_reg    <= '0;
                        case (s_tuser)
                            KIND_FRAME: state_reg <= ST_SCAN;
                            KIND_TICK: begin
                                seconds_reg <= seconds_reg + 32'd1;
                                state_reg   <= ST_OUT;
                            end
                            KIND_PURGE: state_reg <= ST_PURGE;
                            default:    state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (idx_reg == '0) begin
                        // Classify on the first scan cycle.
                        if (len_short) begin
                            verdict_reg <= VERDICT_BAD;
                        end else if (!is_ip) begin
                            verdict_reg <= VERDICT_BCAST;
                        end else if (len_ip_bad) begin
                            verdict_reg <= VERDICT_BAD;
                        end else if (is_igmp) begin
                            if (len_igmp_bad) begin
                                verdict_reg <= VERDICT_BAD;
                            end else if (is_query && grp_reg == 32'd0) begin
                                verdict_reg <= VERDICT_BCAST;
                            end
                        end else if (dest_reg == 32'd0) begin
                            verdict_reg <= VERDICT_BCAST;
                        end
                    end
                    if (scan_match && !hit_reg) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= scan_i;
                    end
                    if (!gvalid_reg[scan_i] && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= scan_i;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (GROUP_W+1)'(GROUP_COUNT - 1)) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    state_reg <= ST_OUT;
                    if (verdict_reg == VERDICT_FWD && !is_igmp) begin
                        mask_reg <= hit_reg ? mmask_reg[hit_idx_reg] : 8'd0;
                    end else if (verdict_reg == VERDICT_FWD && is_query) begin
                        qset_reg <= qset_reg | pbit;
                        if (hit_reg) begin
                            qknown_reg[hit_idx_reg] <= 1'b1;
                            qport_reg[hit_idx_reg]  <= port_reg;
                            mask_reg <= mmask_reg[hit_idx_reg];
                        end else if (free_reg) begin
                            gvalid_reg[free_idx_reg] <= 1'b1;
                            gaddr_reg[free_idx_reg]  <= grp_reg;
                            qknown_reg[free_idx_reg] <= 1'b1;
                            qport_reg[free_idx_reg]  <= port_reg;
                            mmask_reg[free_idx_reg]  <= 8'd0;
                        end else begin
                            full_reg <= 1'b1;
                        end
                    end else if (verdict_reg == VERDICT_BCAST && is_ip && is_igmp &&
                                 is_query) begin
                        // A general query on IPv4; a non-IP frame teaches nothing.
                        qset_reg <= qset_reg | pbit;
                    end else if (verdict_reg == VERDICT_FWD && (is_report || is_leave)) begin
                        // Mask toward the querier; a new group has none.
                        if (grp_reg != 32'd0 && hit_reg && qknown_reg[hit_idx_reg]) begin
                            mask_reg <= pbit_q(qport_reg[hit_idx_reg]);
                        end else begin
                            mask_reg <= qset_reg;
                        end
                        if (grp_reg != 32'd0) begin
                            if (is_report) begin
                                if (hit_reg) begin
                                    mmask_reg[hit_idx_reg] <= mmask_reg[hit_idx_reg] | pbit;
                                end else if (free_reg) begin
                                    gvalid_reg[free_idx_reg] <= 1'b1;
                                    gaddr_reg[free_idx_reg]  <= grp_reg;
                                    qknown_reg[free_idx_reg] <= 1'b0;
                                    mmask_reg[free_idx_reg]  <= pbit;
                                end else begin
                                    full_reg <= 1'b1;
                                end
                            end else if (hit_reg) begin
                                mmask_reg[hit_idx_reg] <= mmask_reg[hit_idx_reg] & ~pbit;
                            end
                        end
                    end
                end
                ST_PURGE: begin
                    // Issue one stamp read per cycle; judge it in the next cycle.
                    prd_addr_reg <= pidx_reg[STAMP_AW-1:0];
                    prd_vld_reg  <= 1'b1;
                    pidx_reg     <= pidx_reg + 1'b1;
                    if (pidx_reg == (STAMP_AW+1)'(STAMP_DEPTH - 1)) begin
                        state_reg <= ST_PWAIT;
                    end
                end
                ST_PWAIT: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (prd_vld_reg) begin
                if (gvalid_reg[prd_addr_reg[STAMP_AW-1:PORT_W]] &&
                    (seconds_reg - prd_data_reg) > {16'd0, timeout_reg}) begin
                    mmask_reg[prd_addr_reg[STAMP_AW-1:PORT_W]][prd_addr_reg[PORT_W-1:0]]
                        <= 1'b0;
                end
            end
        end
    end

endmodule

>>> bench/igmp_snooping_forward_table_checker.sv
`timescale 1ns / 100ps
// Checker for the IGMP snooping forward table: mirrors the group table,
// predicts each result beat and compares it. Depends on igmp_snp_pkg.
module igmp_snooping_forward_table_checker
    import igmp_snp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [15:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending_count,
    output int           checked_count
);

    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] data;
    } fwd_result_t;

    fwd_result_t awaited_results[$];

    // Mirror of the block's table state.
    logic        grp_used [GROUP_COUNT];
    logic [31:0] grp_addr [GROUP_COUNT];
    logic        qr_known [GROUP_COUNT];
    logic [2:0]  qr_port  [GROUP_COUNT];
    logic [7:0]  members  [GROUP_COUNT];
    logic [31:0] stamp    [STAMP_DEPTH];
    logic [7:0]  qr_set;
    logic [31:0] now_sec;
    logic [15:0] timeout_val;

    function automatic int find_group(input logic [31:0] addr);
        for (int g = 0; g < GROUP_COUNT; g++)
            if (grp_used[g] && grp_addr[g] == addr) return g;
        return -1;
    endfunction

    function automatic int find_or_create(input logic [31:0] addr, inout logic full);
        int g;
        g = find_group(addr);
        if (g >= 0) return g;
        for (int e = 0; e < GROUP_COUNT; e++) begin
            if (!grp_used[e]) begin
                grp_used[e] = 1'b1;
                grp_addr[e] = addr;
                qr_known[e] = 1'b0;
                members[e]  = '0;
                return e;
            end
        end
        full = 1'b1;
        return -1;
    endfunction

    function automatic logic [7:0] toward_querier(input logic [31:0] addr);
        int g;
        if (addr == 0) return qr_set;
        g = find_group(addr);
        if (g >= 0 && qr_known[g]) return 8'(1) << qr_port[g];
        return qr_set;
    endfunction

    function automatic fwd_result_t forward_decision(input logic [1:0] kind,
                                                     input logic [119:0] d);
        logic [2:0]  port;
        logic [16:0] len, iphl;
        logic [15:0] etype;
        logic [7:0]  proto, itype, mask;
        logic [31:0] grp, dst;
        logic [1:0]  verd;
        logic        full;
        int          g;
        fwd_result_t r;
        port  = d[2:0];
        len   = {1'b0, d[18:3]};
        etype = d[34:19];
        iphl  = {11'd0, d[38:35], 2'b00};
        proto = d[46:39];
        itype = d[54:47];
        grp   = d[86:55];
        dst   = d[118:87];
        verd  = VERDICT_FWD;
        mask  = '0;
        full  = 1'b0;
        if (kind == KIND_TICK) begin
            now_sec = now_sec + 32'd1;
        end else if (kind == KIND_PURGE) begin
            for (int e = 0; e < GROUP_COUNT; e++)
                for (int p = 0; p < PORT_COUNT; p++)
                    if (grp_used[e] && members[e][p] &&
                        (now_sec - stamp[e * PORT_COUNT + p]) > {16'd0, timeout_val})
                        members[e][p] = 1'b0;
        end else if (kind == KIND_FRAME) begin
            if (len < 14) begin
                verd = VERDICT_BAD;
            end else if (etype != ETH_IPV4) begin
                verd = VERDICT_BCAST;
            end else if (len < 34 || len < 14 + iphl) begin
                verd = VERDICT_BAD;
            end else if (proto == PROTO_IGMP) begin
                if (len < 22 + iphl) begin
                    verd = VERDICT_BAD;
                end else if (itype == T_QUERY) begin
                    qr_set[port] = 1'b1;
                    if (grp == 0) begin
                        verd = VERDICT_BCAST;
                    end else begin
                        g = find_or_create(grp, full);
                        if (g >= 0) begin
                            qr_known[g] = 1'b1;
                            qr_port[g]  = port;
                            mask        = members[g];
                        end
                    end
                end else if (itype == T_REPORT2 || itype == T_REPORT3) begin
                    if (grp != 0) begin
                        g = find_or_create(grp, full);
                        if (g >= 0) begin
                            members[g][port] = 1'b1;
                            stamp[g * PORT_COUNT + port] = now_sec;
                        end
                    end
                    mask = toward_querier(grp);
                end else if (itype == T_LEAVE) begin
                    if (grp != 0) begin
                        g = find_group(grp);
                        if (g >= 0) members[g][port] = 1'b0;
                    end
                    mask = toward_querier(grp);
                end
            end else if (dst == 0) begin
                verd = VERDICT_BCAST;
            end else begin
                g = find_group(dst);
                if (g >= 0) mask = members[g];
            end
        end
        r.verdict = verd;
        r.data    = {7'd0, full, (verd == VERDICT_FWD) ? mask : 8'd0};
        return r;
    endfunction

    always @(posedge aclk) begin
        fwd_result_t want;
        if (!aresetn) begin
            for (int e = 0; e < GROUP_COUNT; e++) begin
                grp_used[e] = 1'b0;
                qr_known[e] = 1'b0;
                members[e]  = '0;
            end
            qr_set      = '0;
            now_sec     = '0;
            timeout_val = TIMEOUT_RESET;
            awaited_results.delete();
        end else begin
            if (cfg_wr_en) timeout_val = cfg_wr_data;
            if (s_tvalid && s_tready)
                awaited_results = {awaited_results, forward_decision(s_tuser, s_tdata)};
            if (m_tvalid && m_tready) begin
                checked_count <= checked_count + 1;
                if (awaited_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: verdict %0d data %04h",
                                 m_tuser, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.verdict !== m_tuser || want.data !== m_tdata) begin
                        if (fail_count < 10)
                            $display("mismatch: expected verdict %0d mask %02h full %0d,",
                                     want.verdict, want.data[7:0], want.data[8],
                                     " got verdict %0d mask %02h full %0d (data %04h)",
                                     m_tuser, m_tdata[7:0], m_tdata[8], m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count <= awaited_results.size();
    end

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

endmodule

>>> bench/tb_igmp_snooping_forward_table_top.sv
`timescale 1ns / 100ps
// Testbench top for the IGMP snooping forward table: makes stimulus and gives
// the verdict. Depends on igmp_snp_pkg and the checker module.
module tb_igmp_snooping_forward_table_top;
    import igmp_snp_pkg::*;

    // Kind code that the block must answer with an all-zero result and ignore.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    // Generous cycle limit.
    localparam int CYCLE_LIMIT = 1_000_000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [15:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;
    logic [1:0]   m_tuser;

    int fail_count, pending_count, checked_count;
    int cycle_count;
    int frame_beats, tick_beats, purge_beats, cfg_writes;
    bit quiet;             // When set, neither side inserts gaps.
    int sink_hold;
    logic [31:0] group_pool[20];

    igmp_snooping_forward_table_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    igmp_snooping_forward_table_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count),
        .checked_count(checked_count)
    );

    always #5 aclk = ~aclk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The result side stalls on its own schedule so that stalls land on every
    // phase of the block's work, including while a result is being held.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready  <= 1'b1;
            sink_hold <= gap_len();
        end
    end

    // A timeout is a failure on its own, whatever the checker has counted.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, pending_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one beat and holds it until the block takes it. The valid is only
    // lowered when a gap follows, so it never gets two assignments in one step.
    task automatic send_beat(input logic [1:0] kind, input logic [119:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        case (kind)
            KIND_FRAME: frame_beats++;
            KIND_TICK:  tick_beats++;
            KIND_PURGE: purge_beats++;
            default: ;
        endcase
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_frame(input logic [2:0] port, input logic [15:0] len,
                              input logic [15:0] etype, input logic [3:0] ihw,
                              input logic [7:0] proto, input logic [7:0] itype,
                              input logic [31:0] grp, input logic [31:0] dst);
        send_beat(KIND_FRAME, {1'b0, dst, grp, itype, proto, ihw, etype, len, port});
    endtask

    // An IGMP frame whose lengths pass every check.
    task automatic send_igmp(input logic [7:0] itype, input logic [31:0] grp);
        logic [3:0]  ihw;
        logic [15:0] len;
        ihw = 4'($urandom_range(0, 15));
        len = 16'(((22 + 4 * ihw) > 34 ? (22 + 4 * ihw) : 34) + $urandom_range(0, 1500));
        send_frame(3'($urandom_range(0, 7)), len, ETH_IPV4, ihw, PROTO_IGMP, itype, grp,
                   $urandom);
    endtask

    // Drops the input valid so that no stale beat is taken twice, then waits
    // until every accepted beat has its result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    // One random beat. Most are well formed and aimed at a small group pool so
    // that the table fills, members age out and queriers get learned.
    task automatic random_beat();
        int r;
        logic [31:0] grp;
        logic [3:0]  ihw;
        r   = $urandom_range(0, 99);
        grp = ($urandom_range(0, 9) == 0) ? 32'd0 : group_pool[$urandom_range(0, 19)];
        ihw = 4'($urandom_range(5, 15));
        if (r < 20)
            send_igmp($urandom_range(0, 1) ? T_REPORT2 : T_REPORT3, grp);
        else if (r < 30)
            send_igmp(T_LEAVE, grp);
        else if (r < 38)
            send_igmp(T_QUERY, grp);
        else if (r < 58)
            send_frame(3'($urandom_range(0, 7)),
                       16'(34 + 4 * ihw + $urandom_range(0, 200)),
                       ETH_IPV4, ihw, 8'($urandom_range(3, 255)), 8'($urandom), $urandom,
                       ($urandom_range(0, 7) == 0) ? $urandom : grp);
        else if (r < 73)
            send_beat(KIND_TICK, 120'({$urandom, $urandom, $urandom, $urandom}));
        else if (r < 76)
            send_beat(KIND_PURGE, 120'({$urandom, $urandom, $urandom, $urandom}));
        else if (r < 80)
            send_beat(KIND_SPARE, 120'({$urandom, $urandom, $urandom, $urandom}));
        else if (r < 87)
            // Lengths around the IP and IGMP thresholds, often too short.
            send_frame(3'($urandom_range(0, 7)), 16'($urandom_range(0, 90)), ETH_IPV4,
                       4'($urandom), $urandom_range(0, 1) ? PROTO_IGMP : 8'($urandom),
                       T_REPORT2, grp, grp);
        else if (r < 91)
            send_frame(3'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
                       8'($urandom), 8'($urandom), $urandom, $urandom);
        else if (r < 95)
            send_igmp(8'($urandom), grp);
        else
            send_beat(2'($urandom_range(0, 3)),
                      120'({$urandom, $urandom, $urandom, $urandom}));
    endtask

    initial begin
        logic [15:0] settings[5];
        aclk        = 1'b0;
        cycle_count = 0;
        frame_beats = 0;
        tick_beats  = 0;
        purge_beats = 0;
        cfg_writes  = 0;
        quiet       = 1'b0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= KIND_FRAME;
        for (int i = 0; i < 20; i++) group_pool[i] = {4'hE, 28'($urandom)};
        group_pool[0] = 32'hFFFF_FFFF;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats: length boundaries, every message type and the odd
        // cases, under the timeout that reset leaves in place.
        send_frame(3'd0, 16'd0,     ETH_IPV4, 4'd5,  PROTO_IGMP, T_REPORT2, 32'd1, 32'd1);
        send_frame(3'd7, 16'hFFFF, 16'hFFFF,  4'hF,  8'hFF, 8'hFF, 32'hFFFF_FFFF, '1);
        send_frame(3'd1, 16'd13,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_QUERY, 32'd0, 32'd0);
        send_frame(3'd1, 16'd14,   16'h86DD, 4'd5,  PROTO_IGMP, T_QUERY, 32'd0, 32'd0);
        send_frame(3'd2, 16'd33,   ETH_IPV4, 4'd5,  8'd17, 8'd0, 32'd0, 32'h1);
        send_frame(3'd2, 16'd34,   ETH_IPV4, 4'd5,  8'd17, 8'd0, 32'd0, 32'd0);
        send_frame(3'd2, 16'd73,   ETH_IPV4, 4'd15, 8'd17, 8'd0, 32'd0, 32'h1);
        send_frame(3'd4, 16'd41,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_REPORT2, group_pool[1],
                   32'd0);
        send_frame(3'd4, 16'd42,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_REPORT2, group_pool[1],
                   32'd0);
        send_frame(3'd7, 16'd64,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_QUERY, 32'd0, 32'd0);
        send_frame(3'd6, 16'd64,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_REPORT3, 32'd0, 32'd0);
        send_frame(3'd3, 16'd64,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_QUERY, group_pool[1],
                   32'd0);
        send_frame(3'd5, 16'd64,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_REPORT2, group_pool[1],
                   32'd0);
        send_frame(3'd0, 16'd100,  ETH_IPV4, 4'd5,  8'd17, 8'd0, 32'd0, group_pool[1]);
        send_frame(3'd5, 16'd64,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_LEAVE, group_pool[1],
                   32'd0);
        send_frame(3'd5, 16'd64,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_LEAVE, group_pool[2],
                   32'd0);
        send_frame(3'd5, 16'd82,   ETH_IPV4, 4'd15, PROTO_IGMP, 8'hFF, group_pool[1],
                   32'd0);
        send_frame(3'd0, 16'd64,   ETH_IPV4, 4'd5,  PROTO_IGMP, T_REPORT3, group_pool[0],
                   32'd0);
        send_beat(KIND_TICK,  '0);
        send_beat(KIND_PURGE, '0);
        send_beat(KIND_SPARE, '1);
        send_frame(3'd0, 16'd100,  ETH_IPV4, 4'd5,  8'd17, 8'd0, 32'd0, group_pool[0]);

        // Random phases, each under its own timeout, extremes included. One
        // phase runs with no gaps on either side.
        settings = '{16'd0, 16'd2, 16'hFFFF, 16'($urandom_range(3, 40)), 16'd1};
        for (int ph = 0; ph < 5; ph++) begin
            write_timeout(settings[ph]);
            quiet = (ph == 3);
            for (int i = 0; i < 80; i++) random_beat();
        end
        quiet = 1'b0;

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("Covered %0d frame beats, %0d ticks and %0d purges over %0d timeout writes;",
                 frame_beats, tick_beats, purge_beats, cfg_writes);
        $display("%0d result beats compared, %0d failures.", checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
